// ===== hdl/phs_pkg.sv =====
// shared types and constants for the point hash set
`timescale 1ns / 1ps
`default_nettype none
package phs_pkg;
  localparam int unsigned SlotsDefault = 1024;
  localparam int unsigned KeyW = 96;
  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvMult = 64'h00000100000001B3;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HM_MUL, S_HM_RED, S_PRB_RD, S_PRB_CHK, S_DONE,
    S_RC_RD, S_RC_CHK, S_RC_PRB_RD, S_RC_PRB_CHK
  } back_st_e;

  typedef struct packed {
    kind_e       kind;
    logic [95:0] key;
    logic [63:0] hash;
  } job_t;
endpackage
`default_nettype wire

// ===== hdl/point_hash_set_core.sv =====
// top level of the point hash set
`timescale 1ns / 1ps
`default_nettype none
// Open-addressed set of 96-bit keys with fnv-1a-64 home slots and linear
// probing. The front end hashes one key byte a cycle and hands the finished
// job to a two-entry queue; it takes a new request only once the last job
// has been handed over. The back end reduces the hash to a home slot 16 bits
// at a time, then reads and checks one probed slot after another (one ram
// port); a removal adds a probe walk for each key of the following cluster.
// A result is held valid until it is taken, and the back end takes its next
// job only after the result transfer. After reset a clearing pass over all
// slots clears the slot flags before the first request is served.
module point_hash_set_core import phs_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // key_x, key_y, key_z
  input  wire logic [1:0]   s_axis_tuser,  // kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [23:0]       m_axis_tdata   // status, slot_index, entries_held, pad
);
  logic fv, fr, qv, qr;
  job_t fj, qj;
  logic [1:0]  st;
  logic [9:0]  si;
  logic [10:0] eh;

  phs_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(s_axis_tuser), .key_i(s_axis_tdata),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj)
  );
  phs_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(fv), .in_ready_o(fr), .in_i(fj),
    .out_valid_o(qv), .out_ready_i(qr), .out_o(qj)
  );
  phs_back #(.Slots(Slots)) u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_ready_o(qr), .job_i(qj),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .status_o(st), .slot_index_o(si), .entries_held_o(eh)
  );
  assign m_axis_tdata = {1'b0, eh, si, st};
endmodule
`default_nettype wire

// ===== hdl/phs_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module phs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/phs_front.sv =====
// front end: accepts requests and computes the fnv-1a hash one byte a cycle
`timescale 1ns / 1ps
`default_nettype none
module phs_front import phs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [95:0] key_i,
  output logic             job_valid_o,
  input  wire logic        job_ready_i,
  output job_t             job_o
);
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] hash_q, hash_d;
  logic [95:0] key_q;
  logic [1:0]  kind_q;
  logic [63:0] mixed;
  logic [7:0]  byte_sel;

  assign in_ready_o  = !busy_q;
  assign byte_sel    = key_q[{cnt_q, 3'b000} +: 8];
  assign mixed       = hash_q ^ {56'd0, byte_sel};
  assign job_valid_o = done_q;
  assign job_o       = '{kind: kind_e'(kind_q), key: key_q, hash: hash_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    hash_d = hash_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        cnt_d  = 4'd0;
        hash_d = FnvBasis;
      end
    end else if (!done_q) begin
      // prime is 2^40 + 0x1b3
      hash_d = {mixed[23:0], 40'd0} + (mixed * 64'h1B3);
      cnt_d  = cnt_q + 4'd1;
      if (cnt_q == 4'd11) begin
        done_d = 1'b1;
      end
    end else if (job_ready_i) begin
      done_d = 1'b0;
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    if (!busy_q && in_valid_i) begin
      key_q  <= key_i;
      kind_q <= kind_i;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/phs_queue.sv =====
// two-entry job queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module phs_queue import phs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  job_t      in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output job_t      out_o
);
  job_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o       = buf_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_i;
  end
endmodule
`default_nettype wire

// ===== hdl/phs_back.sv =====
// back end: probe, insert, remove with cluster re-placement
`timescale 1ns / 1ps
`default_nettype none
module phs_back import phs_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  job_t             job_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [1:0]       status_o,
  output logic [9:0]       slot_index_o,
  output logic [10:0]      entries_held_o
);
  localparam int unsigned AW = $clog2(Slots);
  localparam int unsigned CW = AW + 1;
  localparam logic [AW-1:0] LastSlot = AW'(Slots - 1);
  localparam int unsigned EW = KeyW + AW;
  localparam int unsigned RecShift = 32 + AW;
  localparam logic [63:0] RecipFull = (64'd1 << RecShift) / 64'(Slots);
  localparam logic [32:0] Recip = RecipFull[32:0];
  localparam logic [33:0] SlotsW = 34'(Slots);

  back_st_e      st_q, st_d;
  logic          ram_we;
  logic [AW-1:0] ram_addr, addr_q, addr_d, jpos_q, jpos_d;
  logic [AW-1:0] home_q, home_d;
  logic [EW:0]   ram_wdata, ram_rdata;
  logic          rd_valid;
  logic [CW-1:0] n_q, n_d, cnt_q, cnt_d, clr_q, clr_d;
  logic [95:0]   key_q, key_d, mkey_q, mkey_d;
  logic [AW-1:0] mhome_q, mhome_d;
  kind_e         kind_q;
  logic [1:0]    sts_q, sts_d;
  logic [AW-1:0] slot_q, slot_d;
  logic          rv_q, rv_d, take;
  logic [63:0]   hsh_q, hsh_d;
  logic [1:0]    dig_q, dig_d;
  logic [AW-1:0] rem_q, rem_d;
  logic [31:0]   tv_q, tv_d;
  logic [64:0]   prod_q, prod_d;
  logic [32:0]   qest;
  logic [33:0]   rsub, rfix;

  // word layout: valid flag, home slot, key
  phs_ram #(.Width(EW + 1), .Depth(Slots)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  assign rd_valid       = ram_rdata[EW];
  assign job_ready_o    = (st_q == S_IDLE) && !rv_q;
  assign take           = job_valid_i && job_ready_o;
  assign res_valid_o    = rv_q;
  assign status_o       = sts_q;
  assign slot_index_o   = 10'(slot_q);
  assign entries_held_o = 11'(cnt_q);

  // hash mod slots, 16 bits at a time by reciprocal multiplication
  assign qest = 33'(prod_q >> RecShift);
  assign rsub = 34'(tv_q) - 34'(qest) * SlotsW;
  assign rfix = (rsub >= SlotsW) ? rsub - SlotsW : rsub;

  always_comb begin
    st_d = st_q; addr_d = addr_q; jpos_d = jpos_q; home_d = home_q;
    n_d = n_q; cnt_d = cnt_q; clr_d = clr_q; key_d = key_q; mkey_d = mkey_q;
    mhome_d = mhome_q; sts_d = sts_q; slot_d = slot_q; rv_d = rv_q;
    hsh_d = hsh_q; dig_d = dig_q; rem_d = rem_q; tv_d = tv_q; prod_d = prod_q;
    ram_we = 1'b0; ram_addr = addr_q; ram_wdata = {1'b0, home_q, key_q};
    if (rv_q && res_ready_i) rv_d = 1'b0;
    unique case (st_q)
      S_CLEAR: begin
        ram_we = 1'b1; ram_addr = clr_q[AW-1:0]; ram_wdata = '0;
        clr_d = clr_q + CW'(1);
        if (clr_q[AW-1:0] == LastSlot) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          key_d = job_i.key; hsh_d = job_i.hash; rem_d = '0; dig_d = '0;
          st_d = S_HM_MUL;
        end
      end
      S_HM_MUL: begin
        tv_d = {16'(rem_q), hsh_q[63:48]};
        prod_d = {33'd0, tv_d} * {32'd0, Recip};
        st_d = S_HM_RED;
      end
      S_HM_RED: begin
        rem_d = AW'(rfix);
        hsh_d = {hsh_q[47:0], 16'd0};
        dig_d = dig_q + 2'd1;
        if (dig_q == 2'd3) begin
          home_d = AW'(rfix); addr_d = AW'(rfix); n_d = '0; st_d = S_PRB_RD;
        end else begin
          st_d = S_HM_MUL;
        end
      end
      S_PRB_RD: st_d = S_PRB_CHK;
      S_PRB_CHK: begin
        st_d = S_DONE;
        if (n_q == CW'(Slots)) begin
          sts_d = (kind_q == KIND_INSERT) ? ST_FULL : ST_ABSENT; slot_d = '0;
        end else if (!rd_valid) begin
          if (kind_q == KIND_INSERT) begin
            ram_we = 1'b1; ram_wdata = {1'b1, home_q, key_q}; cnt_d = cnt_q + CW'(1);
            sts_d = ST_OK; slot_d = addr_q;
          end else begin
            sts_d = ST_ABSENT; slot_d = '0;
          end
        end else if (ram_rdata[95:0] == key_q) begin
          sts_d = (kind_q == KIND_INSERT) ? ST_PRESENT : ST_OK; slot_d = addr_q;
          if (kind_q == KIND_REMOVE) begin
            ram_we = 1'b1; ram_wdata = {1'b0, home_q, key_q}; n_d = CW'(1);
            jpos_d = (addr_q == LastSlot) ? '0 : addr_q + AW'(1);
            if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
            st_d = S_RC_RD;
          end
        end else begin
          n_d = n_q + CW'(1);
          addr_d = (addr_q == LastSlot) ? '0 : addr_q + AW'(1);
          st_d = S_PRB_RD;
        end
        if (st_d == S_DONE) rv_d = 1'b1;
        if (st_d == S_PRB_RD) ram_addr = addr_d;
      end
      S_RC_RD: begin
        ram_addr = jpos_q; st_d = S_RC_CHK;
        if (n_q == CW'(Slots)) begin st_d = S_DONE; rv_d = 1'b1; end
      end
      S_RC_CHK: begin
        ram_addr = jpos_q;
        if (!rd_valid) begin
          st_d = S_DONE; rv_d = 1'b1;
        end else begin
          mkey_d = ram_rdata[95:0]; mhome_d = ram_rdata[EW-1:96];
          ram_we = 1'b1; ram_wdata = {1'b0, ram_rdata[EW-1:0]};
          addr_d = ram_rdata[EW-1:96]; st_d = S_RC_PRB_RD;
        end
      end
      S_RC_PRB_RD: begin ram_addr = addr_q; st_d = S_RC_PRB_CHK; end
      S_RC_PRB_CHK: begin
        ram_addr = addr_q;
        if (!rd_valid || addr_q == jpos_q) begin
          ram_we = 1'b1; ram_wdata = {1'b1, mhome_q, mkey_q};
          n_d = n_q + CW'(1);
          jpos_d = (jpos_q == LastSlot) ? '0 : jpos_q + AW'(1);
          st_d = S_RC_RD;
        end else begin
          addr_d = (addr_q == LastSlot) ? '0 : addr_q + AW'(1);
          st_d = S_RC_PRB_RD;
        end
      end
      S_DONE: if (!rv_q) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR; cnt_q <= '0; clr_q <= '0; rv_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; clr_q <= clr_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d; jpos_q <= jpos_d; home_q <= home_d;
    n_q <= n_d; key_q <= key_d; mkey_q <= mkey_d; mhome_q <= mhome_d;
    sts_q <= sts_d; slot_q <= slot_d;
    hsh_q <= hsh_d; dig_q <= dig_d; rem_q <= rem_d; tv_q <= tv_d; prod_q <= prod_d;
    if (take) kind_q <= job_i.kind;
  end
endmodule
`default_nettype wire
